// ===== hdl/rcdm_pkg.sv =====
package rcdm_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CENTER_DZ  = 3'd0;
    localparam logic [2:0] CFG_STOP_DZ    = 3'd1;
    localparam logic [2:0] CFG_RESTART_DZ = 3'd2;
    localparam logic [2:0] CFG_SWITCH_LOW = 3'd3;
    localparam logic [2:0] CFG_SWITCH_HI  = 3'd4;
    localparam logic [2:0] CFG_MAX_ERPM   = 3'd5;

    // Pulse window and stick geometry in microseconds.
    localparam logic [15:0] PULSE_MIN    = 16'd800;
    localparam logic [15:0] PULSE_MAX    = 16'd2200;
    localparam logic [11:0] PULSE_MID    = 12'd1500;
    localparam logic [15:0] THROTTLE_LOW = 16'd1000;
    localparam logic [15:0] THROTTLE_HI  = 16'd2000;
    localparam logic [9:0]  STICK_CLAMP  = 10'd500;
    localparam logic [9:0]  LEVEL_FULL   = 10'd1000;

    // Three-position switch codes.
    localparam logic [1:0] SW_LOW  = 2'd0;
    localparam logic [1:0] SW_MID  = 2'd1;
    localparam logic [1:0] SW_HIGH = 2'd2;

    // Gripper servo pulses in microseconds.
    localparam logic [11:0] SERVO_MIN      = 12'd550;
    localparam logic [11:0] SERVO_MID      = 12'd1500;
    localparam logic [11:0] SERVO_HIGH_POS = 12'd2278;
    localparam logic [11:0] SERVO_LOW_POS  = 12'd1944;

    // Divisor of the shared scale unit, and its rounded-up reciprocal
    // 2^35 / 1000 with the matching shift.
    localparam logic [10:0] SCALE_DIV   = 11'd1000;
    localparam logic [25:0] SCALE_RECIP = 26'd34359739;
    localparam int          SCALE_SHIFT = 35;

    typedef struct packed {
        logic [8:0]  center_dz;
        logic [9:0]  stop_dz;
        logic [9:0]  restart_dz;
        logic [11:0] switch_low;
        logic [11:0] switch_high;
        logic [14:0] max_erpm;
    } cfg_t;

    typedef struct packed {
        logic signed [10:0] move_lv;
        logic signed [10:0] turn_lv;
        logic [9:0]         speed;
        logic signed [10:0] lift_lv;
        logic [1:0]         grip_pos;
        logic [1:0]         plat;
        logic               move_near_stop;
        logic               steer_near_stop;
        logic               move_near_restart;
        logic               steer_near_restart;
    } frame_t;

endpackage

// ===== hdl/rcdm_decode.sv =====
module rcdm_decode (
    input  logic [15:0]        steer_pulse,
    input  logic [15:0]        move_pulse,
    input  logic [15:0]        speed_pulse,
    input  logic [15:0]        lift_pulse,
    input  logic [15:0]        grip_pulse,
    input  logic [15:0]        platform_pulse,
    input  rcdm_pkg::cfg_t     cfg,
    output rcdm_pkg::frame_t   frame
);

    function automatic logic pulse_ok(input logic [15:0] p);
        return (p >= rcdm_pkg::PULSE_MIN) && (p <= rcdm_pkg::PULSE_MAX);
    endfunction

    // Magnitude of the offset from center; only meaningful for a valid pulse.
    function automatic logic [9:0] offset_mag(input logic [15:0] p);
        logic signed [11:0] v;
        logic [11:0]        m;
        v = $signed(p[11:0] - rcdm_pkg::PULSE_MID);
        m = (v < 0) ? 12'(-v) : 12'(v);
        return m[9:0];
    endfunction

    function automatic logic offset_neg(input logic [15:0] p);
        return p[11:0] < rcdm_pkg::PULSE_MID;
    endfunction

    // Signed stick level with center deadzone and clamp at full travel.
    function automatic logic signed [10:0] stick_level(input logic [15:0] p,
                                                       input logic [8:0]  dz);
        logic [9:0]  m;
        logic [10:0] lv;
        m = offset_mag(p);
        if (!pulse_ok(p) || (m < {1'b0, dz})) begin
            return '0;
        end
        if (m > rcdm_pkg::STICK_CLAMP) begin
            m = rcdm_pkg::STICK_CLAMP;
        end
        lv = {m, 1'b0};
        return offset_neg(p) ? $signed(11'(-lv)) : $signed(lv);
    endfunction

    // An invalid pulse counts as centered.
    function automatic logic near_center(input logic [15:0] p, input logic [9:0] dz);
        return !pulse_ok(p) || (offset_mag(p) <= dz);
    endfunction

    function automatic logic [1:0] three_pos(input logic [15:0] p,
                                             input logic [11:0] lo,
                                             input logic [11:0] hi);
        if (!pulse_ok(p)) begin
            return rcdm_pkg::SW_MID;
        end
        if (p <= {4'd0, lo}) begin
            return rcdm_pkg::SW_LOW;
        end
        if (p >= {4'd0, hi}) begin
            return rcdm_pkg::SW_HIGH;
        end
        return rcdm_pkg::SW_MID;
    endfunction

    logic [15:0] speed_off;

    assign speed_off = speed_pulse - rcdm_pkg::THROTTLE_LOW;

    // Per-channel decode of one frame.
    always_comb begin
        frame.move_lv  = stick_level(move_pulse, cfg.center_dz);
        frame.turn_lv  = 11'(-stick_level(steer_pulse, cfg.center_dz));
        frame.lift_lv  = stick_level(lift_pulse, cfg.center_dz);
        frame.grip_pos = three_pos(grip_pulse, cfg.switch_low, cfg.switch_high);
        frame.plat     = three_pos(platform_pulse, cfg.switch_low, cfg.switch_high);

        if (!pulse_ok(speed_pulse) || (speed_pulse <= rcdm_pkg::THROTTLE_LOW)) begin
            frame.speed = '0;
        end else if (speed_pulse >= rcdm_pkg::THROTTLE_HI) begin
            frame.speed = rcdm_pkg::LEVEL_FULL;
        end else begin
            frame.speed = speed_off[9:0];
        end

        frame.move_near_stop     = near_center(move_pulse, cfg.stop_dz);
        frame.steer_near_stop    = near_center(steer_pulse, cfg.stop_dz);
        frame.move_near_restart  = near_center(move_pulse, cfg.restart_dz);
        frame.steer_near_restart = near_center(steer_pulse, cfg.restart_dz);
    end

endmodule

// ===== hdl/rcdm_scale.sv =====
module rcdm_scale (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [9:0]  a_mag,
    input  logic [14:0] b_mag,
    output logic        done,
    output logic [14:0] quot
);

    logic [24:0] prod;
    logic [24:0] prod_reg;
    logic [50:0] recip_prod;
    logic        step_reg;
    logic        done_reg;
    logic [14:0] quot_reg;

    // The product of a 10-bit level and a 15-bit factor stays below 2^25.
    assign prod = {15'd0, a_mag} * {10'd0, b_mag};

    // Divide by 1000 as a multiply by the rounded-up reciprocal and a shift.
    // The rounding error times any 25-bit product stays below 2^35, so the
    // quotient is exact.
    assign recip_prod = {26'd0, prod_reg} * {25'd0, rcdm_pkg::SCALE_RECIP};

    assign done = done_reg;
    assign quot = quot_reg;

    // Registers the product on start, then the quotient, with done raised as the quotient is registered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= start;
            done_reg <= step_reg;
            if (start) begin
                prod_reg <= prod;
            end
            if (step_reg) begin
                quot_reg <= 15'(recip_prod >> rcdm_pkg::SCALE_SHIFT);
            end
        end
    end

endmodule

// ===== hdl/rc_drive_mixer_core.sv =====
// Each accepted item steps through ST_MIX_GO, ST_MIX_WAIT, ST_ERPM_GO,
// ST_ERPM_WAIT and ST_OUT before the next is taken; the shared multiply and
// divide-by-1000 unit runs twice per item.
// s_tready is high only while the sequencer is idle; a result not taken holds it.
// Reset (aresetn low, synchronous) loads the default registers, sets the
// stop latch, clears the gripper-seen flag and drops any pending result.
module rc_drive_mixer_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data,
    // Input frame.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: steer_pulse, move_pulse, speed_pulse, lift_pulse,
    // grip_pulse, platform_pulse (16 bits each).
    input  logic [95:0] s_tdata,
    // s_tuser: grip_fresh.
    input  logic        s_tuser,
    // Result.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: left_erpm (16), right_erpm (16), move_level (11),
    // turn_level (11), speed_level (10), lift_level (11), grip_position (2),
    // platform_pos (2), servo_pulse (12), then 5 zero bits.
    output logic [95:0] m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_GO,
        ST_MIX_WAIT,
        ST_ERPM_GO,
        ST_ERPM_WAIT,
        ST_OUT
    } state_t;

    state_t             state_reg;
    rcdm_pkg::cfg_t     cfg_reg;
    rcdm_pkg::frame_t   frame;
    logic               stop_reg;
    logic               stop_next;
    logic               grip_seen_reg;
    logic               grip_seen_next;
    logic               s_accept;
    logic [11:0]        servo_next;

    // Per-item working registers.
    logic signed [10:0] move_lv_reg;
    logic signed [10:0] turn_lv_reg;
    logic [9:0]         speed_reg;
    logic signed [10:0] lift_lv_reg;
    logic [1:0]         grip_pos_reg;
    logic [1:0]         plat_reg;
    logic [11:0]        servo_reg;
    logic [9:0]         sel_mag_reg;
    logic               sel_neg_reg;
    logic               turn_sel_reg;
    logic [9:0]         mix_mag_reg;
    logic [14:0]        erpm_mag_reg;

    logic signed [10:0] move_lv_next;
    logic signed [10:0] turn_lv_next;
    logic signed [10:0] sel_lv_next;

    logic               unit_start;
    logic [9:0]         unit_a;
    logic [14:0]        unit_b;
    logic               unit_done;
    logic [14:0]        unit_q;

    logic [15:0]        erpm_pos;
    logic [15:0]        left_erpm;
    logic [15:0]        right_erpm;

    logic               m_tvalid_reg;
    logic [95:0]        m_tdata_reg;
    logic               out_load;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_dz   <= 9'd40;
            cfg_reg.stop_dz     <= 10'd80;
            cfg_reg.restart_dz  <= 10'd120;
            cfg_reg.switch_low  <= 12'd1300;
            cfg_reg.switch_high <= 12'd1700;
            cfg_reg.max_erpm    <= 15'd25000;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rcdm_pkg::CFG_CENTER_DZ:  cfg_reg.center_dz   <= cfg_data[8:0];
                rcdm_pkg::CFG_STOP_DZ:    cfg_reg.stop_dz     <= cfg_data[9:0];
                rcdm_pkg::CFG_RESTART_DZ: cfg_reg.restart_dz  <= cfg_data[9:0];
                rcdm_pkg::CFG_SWITCH_LOW: cfg_reg.switch_low  <= cfg_data[11:0];
                rcdm_pkg::CFG_SWITCH_HI:  cfg_reg.switch_high <= cfg_data[11:0];
                rcdm_pkg::CFG_MAX_ERPM:   cfg_reg.max_erpm    <= cfg_data;
                default: ;
            endcase
        end
    end

    rcdm_decode u_decode (
        .steer_pulse    (s_tdata[15:0]),
        .move_pulse     (s_tdata[31:16]),
        .speed_pulse    (s_tdata[47:32]),
        .lift_pulse     (s_tdata[63:48]),
        .grip_pulse     (s_tdata[79:64]),
        .platform_pulse (s_tdata[95:80]),
        .cfg            (cfg_reg),
        .frame          (frame)
    );

    // Stop latch with separate set and release deadzones.
    always_comb begin
        stop_next = stop_reg;
        if (frame.move_near_stop && frame.steer_near_stop) begin
            stop_next = 1'b1;
        end else if (stop_reg &&
                     (!frame.move_near_restart || !frame.steer_near_restart)) begin
            stop_next = 1'b0;
        end
    end

    // Levels after the latch, and the level picked for the drive mix.
    always_comb begin
        move_lv_next = stop_next ? 11'sd0 : frame.move_lv;
        turn_lv_next = stop_next ? 11'sd0 : frame.turn_lv;
        sel_lv_next  = (turn_lv_next != 0) ? turn_lv_next : move_lv_next;
    end

    // Gripper servo selection; climb mode parks the servo.
    always_comb begin
        grip_seen_next = grip_seen_reg;
        servo_next     = rcdm_pkg::SERVO_MIN;
        if (frame.plat != rcdm_pkg::SW_HIGH) begin
            grip_seen_next = grip_seen_reg || s_tuser;
            if (grip_seen_next) begin
                unique case (frame.grip_pos)
                    rcdm_pkg::SW_HIGH: servo_next = rcdm_pkg::SERVO_HIGH_POS;
                    rcdm_pkg::SW_LOW:  servo_next = rcdm_pkg::SERVO_LOW_POS;
                    default:           servo_next = rcdm_pkg::SERVO_MID;
                endcase
            end
        end
    end

    // Shared unit: first level * throttle / 1000, then mix * max_erpm / 1000.
    assign unit_start = (state_reg == ST_MIX_GO) || (state_reg == ST_ERPM_GO);
    assign unit_a     = (state_reg == ST_MIX_GO) ? sel_mag_reg : mix_mag_reg;
    assign unit_b     = (state_reg == ST_MIX_GO) ? {5'd0, speed_reg} : cfg_reg.max_erpm;

    rcdm_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (unit_start),
        .a_mag   (unit_a),
        .b_mag   (unit_b),
        .done    (unit_done),
        .quot    (unit_q)
    );

    // Left is negated; right follows left on a turn and mirrors it on a move.
    always_comb begin
        erpm_pos   = {1'b0, erpm_mag_reg};
        left_erpm  = sel_neg_reg ? erpm_pos : 16'(-erpm_pos);
        right_erpm = turn_sel_reg ? left_erpm : 16'(-left_erpm);
    end

    // Sequencer, per-item registers and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            stop_reg      <= 1'b1;
            grip_seen_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // The result register loads from ST_OUT, otherwise empties when taken.
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {5'd0, servo_reg, plat_reg, grip_pos_reg,
                                 lift_lv_reg, speed_reg, turn_lv_reg,
                                 move_lv_reg, right_erpm, left_erpm};
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        stop_reg      <= stop_next;
                        grip_seen_reg <= grip_seen_next;
                        move_lv_reg   <= move_lv_next;
                        turn_lv_reg   <= turn_lv_next;
                        speed_reg     <= frame.speed;
                        lift_lv_reg   <= frame.lift_lv;
                        grip_pos_reg  <= frame.grip_pos;
                        plat_reg      <= frame.plat;
                        servo_reg     <= servo_next;
                        sel_neg_reg   <= sel_lv_next < 0;
                        sel_mag_reg   <= (sel_lv_next < 0) ? 10'(-sel_lv_next)
                                                           : 10'(sel_lv_next);
                        turn_sel_reg  <= turn_lv_next != 0;
                        state_reg     <= ST_MIX_GO;
                    end
                end
                ST_MIX_GO: begin
                    state_reg <= ST_MIX_WAIT;
                end
                ST_MIX_WAIT: begin
                    if (unit_done) begin
                        mix_mag_reg <= unit_q[9:0];
                        state_reg   <= ST_ERPM_GO;
                    end
                end
                ST_ERPM_GO: begin
                    state_reg <= ST_ERPM_WAIT;
                end
                ST_ERPM_WAIT: begin
                    if (unit_done) begin
                        erpm_mag_reg <= unit_q;
                        state_reg    <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/rcdm_checker.sv =====
module rcdm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // A stalled result keeps its valid and its data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // After an item is taken the block is busy for the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while still working");

    // Throttle level never exceeds full scale.
    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63:54] <= 10'd1000)
        else $error("speed level out of range");

    // Switch positions are three-position codes.
    a_switch_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[76:75] != 2'd3) && (m_tdata[78:77] != 2'd3))
        else $error("switch position code out of range");

    // Servo pulse is one of the four fixed positions.
    a_servo_values: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[90:79] == 12'd550) || (m_tdata[90:79] == 12'd1500) ||
                     (m_tdata[90:79] == 12'd1944) || (m_tdata[90:79] == 12'd2278))
        else $error("servo pulse not a known position");

endmodule

bind rc_drive_mixer_core rcdm_checker u_rcdm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
